[hw/rtl/abkf_pkg.sv]
// types and constants shared by the angle/bias kalman filter
package abkf_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned DtW   = 16;
    localparam int unsigned ProdW = 64;
    localparam int unsigned DivW  = 64;

    localparam logic [31:0] QAngleRst   = 32'd1073742;
    localparam logic [31:0] QBiasRst    = 32'd3221225;
    localparam logic [31:0] RMeasureRst = 32'd32212255;

    localparam logic [1:0] RegQAngle   = 2'd0;
    localparam logic [1:0] RegQBias    = 2'd1;
    localparam logic [1:0] RegRMeasure = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_M_ANG,
        ST_A_ANG,
        ST_M_T,
        ST_A_T,
        ST_M_AA,
        ST_A_AA,
        ST_M_BB,
        ST_A_BB,
        ST_DIV0_START,
        ST_DIV0_WAIT,
        ST_DIV1_START,
        ST_DIV1_WAIT,
        ST_INNOV,
        ST_M_K0Y,
        ST_A_K0Y,
        ST_M_K1Y,
        ST_A_K1Y,
        ST_M_P00,
        ST_A_P00,
        ST_M_P01,
        ST_A_P01,
        ST_M_P10,
        ST_A_P10,
        ST_M_P11,
        ST_A_P11,
        ST_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/abkf_div.sv]
// restoring divider, signed 64 by 64 bits, one quotient bit per cycle, truncating
module abkf_div
    import abkf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [DivW-1:0] i_num,
    input  logic signed [DivW-1:0] i_den,
    output logic                   o_done,
    output logic signed [DivW-1:0] o_quo
);

    localparam int unsigned CntW = $clog2(DivW + 1);

    logic [DivW-1:0] r_quo, n_quo;
    logic [DivW:0]   r_rem, n_rem;
    logic [DivW-1:0] r_den, n_den;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_neg, n_neg;
    logic            r_done, n_done;
    logic [DivW:0]   shifted;
    logic [DivW:0]   diff;

    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_neg   = r_neg;
        n_done  = 1'b0;
        shifted = {r_rem[DivW-1:0], r_quo[DivW-1]};
        diff    = shifted - {1'b0, r_den};
        if (i_start) begin
            n_quo  = i_num[DivW-1] ? DivW'(-i_num) : i_num;
            n_den  = i_den[DivW-1] ? DivW'(-i_den) : i_den;
            n_rem  = '0;
            n_cnt  = CntW'(DivW);
            n_busy = 1'b1;
            n_neg  = i_num[DivW-1] ^ i_den[DivW-1];
        end else if (r_busy) begin
            if (!diff[DivW]) begin
                n_rem = diff;
                n_quo = {r_quo[DivW-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[DivW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_neg) begin
                    n_quo = DivW'(-n_quo);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[hw/rtl/angle_bias_kalman_filter.sv]
// top level: two-state angle/bias kalman filter with shared multiplier and divider
//
//  channel | signals                  | payload
//  s_axis  | i_s_axis_tvalid/tready   | tdata {time_step, gyro_rate, measured_angle}, tuser restart
//  m_axis  | o_m_axis_tvalid/tready   | tdata {unbiased_rate, filtered_angle}
//  config  | i_cfg_we/i_cfg_addr      | i_cfg_wdata, index 0..2
//
// a filter request runs from acceptance to a valid result through the two gain
// divisions in the shared divider (each with start, 64 quotient steps, done), plus
// 10 multiply/add pairs and 3 further steps (rate, innovation, output). a zero innovation
// variance skips the divisions; a restart request goes straight to the output step.
// one request is in work at a time; tready stays low until the result has been taken.
// reset is synchronous; state clears to zero and registers load their defaults.
module angle_bias_kalman_filter
    import abkf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [87:0] i_s_axis_tdata,  // measured_angle, gyro_rate, time_step, zero pad
    input  logic        i_s_axis_tuser,  // restart
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,  // filtered_angle, unbiased_rate
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    t_state r_state, n_state;

    logic [31:0] r_q_angle, r_q_bias, r_r_measure;
    logic signed [31:0] r_ang, n_ang, r_bias, n_bias, r_rate, n_rate;
    logic signed [31:0] r_aa, n_aa, r_ab, n_ab, r_ba, n_ba, r_bb, n_bb;
    logic signed [31:0] r_p00, n_p00, r_p01, n_p01;
    logic signed [31:0] r_meas, n_meas, r_gyro, n_gyro;
    logic [15:0]        r_dt, n_dt;
    logic signed [31:0] r_t, n_t, r_k0, n_k0, r_k1, n_k1, r_y, n_y;
    logic signed [63:0] r_s, n_s;
    logic signed [63:0] r_prod;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [63:0] r_dnum, n_dnum;
    logic               r_ovalid, n_ovalid;
    logic [63:0]        r_odata, n_odata;
    logic               div_start, div_done;
    logic signed [63:0] div_quo;
    logic signed [65:0] sum;
    logic signed [33:0] inner;
    logic               take;

    // shared multiplier with registered product
    assign mul_p = 68'(mul_a) * 68'(mul_b);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
    end

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_dnum),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign take = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;

    always_comb begin
        n_state = r_state;
        n_ang = r_ang; n_bias = r_bias; n_rate = r_rate;
        n_aa = r_aa; n_ab = r_ab; n_ba = r_ba; n_bb = r_bb;
        n_p00 = r_p00; n_p01 = r_p01;
        n_meas = r_meas; n_gyro = r_gyro; n_dt = r_dt;
        n_t = r_t; n_k0 = r_k0; n_k1 = r_k1; n_y = r_y; n_s = r_s;
        n_dnum = r_dnum;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata = r_odata;
        div_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        sum = '0;
        inner = 34'(r_t) - 34'(r_ab) - 34'(r_ba) + 34'($signed({1'b0, r_q_angle}));
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_meas = i_s_axis_tdata[31:0];
                    n_gyro = i_s_axis_tdata[63:32];
                    n_dt   = i_s_axis_tdata[79:64];
                    if (i_s_axis_tuser) begin
                        n_ang = i_s_axis_tdata[31:0];
                        n_bias = '0;
                        n_rate = i_s_axis_tdata[63:32];
                        n_aa = '0; n_ab = '0; n_ba = '0; n_bb = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_RATE;
                    end
                end
            end
            ST_RATE: begin
                sum = 66'(r_gyro) - 66'(r_bias);
                n_rate = sat32(sum);
                n_state = ST_M_ANG;
            end
            ST_M_ANG: begin
                mul_a = 34'($signed({1'b0, r_dt}));
                mul_b = 34'(r_rate);
                n_state = ST_A_ANG;
            end
            ST_A_ANG: begin
                sum = 66'(r_ang) + 66'(r_prod >>> 16);
                n_ang = sat32(sum);
                n_state = ST_M_T;
            end
            ST_M_T: begin
                mul_a = 34'($signed({1'b0, r_dt}));
                mul_b = 34'(r_bb);
                n_state = ST_A_T;
            end
            ST_A_T: begin
                n_t = 32'(r_prod >>> 16);
                n_state = ST_M_AA;
            end
            ST_M_AA: begin
                mul_a = 34'($signed({1'b0, r_dt}));
                mul_b = inner;
                sum = 66'(r_ab) - 66'(r_t);
                n_ab = sat32(sum);
                n_state = ST_A_AA;
            end
            ST_A_AA: begin
                sum = 66'(r_aa) + 66'(r_prod >>> 16);
                n_aa = sat32(sum);
                sum = 66'(r_ba) - 66'(r_t);
                n_ba = sat32(sum);
                n_state = ST_M_BB;
            end
            ST_M_BB: begin
                mul_a = 34'($signed({1'b0, r_dt}));
                mul_b = 34'($signed({1'b0, r_q_bias}));
                n_s = 64'(r_aa) + 64'($signed({1'b0, r_r_measure}));
                n_dnum = 64'(r_aa) <<< 30;
                n_state = ST_A_BB;
            end
            ST_A_BB: begin
                sum = 66'(r_bb) + 66'(r_prod >>> 16);
                n_bb = sat32(sum);
                n_p00 = r_aa;
                n_p01 = r_ab;
                if (r_s == 64'sd0) begin
                    n_k0 = '0;
                    n_k1 = '0;
                    n_state = ST_INNOV;
                end else begin
                    n_state = ST_DIV0_START;
                end
            end
            ST_DIV0_START: begin
                div_start = 1'b1;
                n_state = ST_DIV0_WAIT;
            end
            ST_DIV0_WAIT: begin
                if (div_done) begin
                    n_k0 = sat32(66'(div_quo));
                    n_dnum = 64'(r_ba) <<< 30;
                    n_state = ST_DIV1_START;
                end
            end
            ST_DIV1_START: begin
                div_start = 1'b1;
                n_state = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT: begin
                if (div_done) begin
                    n_k1 = sat32(66'(div_quo));
                    n_state = ST_INNOV;
                end
            end
            ST_INNOV: begin
                sum = 66'(r_meas) - 66'(r_ang);
                n_y = sat32(sum);
                n_state = ST_M_K0Y;
            end
            ST_M_K0Y: begin
                mul_a = 34'(r_k0); mul_b = 34'(r_y);
                n_state = ST_A_K0Y;
            end
            ST_A_K0Y: begin
                sum = 66'(r_ang) + 66'(r_prod >>> 30);
                n_ang = sat32(sum);
                n_state = ST_M_K1Y;
            end
            ST_M_K1Y: begin
                mul_a = 34'(r_k1); mul_b = 34'(r_y);
                n_state = ST_A_K1Y;
            end
            ST_A_K1Y: begin
                sum = 66'(r_bias) + 66'(r_prod >>> 30);
                n_bias = sat32(sum);
                n_state = ST_M_P00;
            end
            ST_M_P00: begin
                mul_a = 34'(r_k0); mul_b = 34'(r_p00);
                n_state = ST_A_P00;
            end
            ST_A_P00: begin
                sum = 66'(r_p00) - 66'(r_prod >>> 30);
                n_aa = sat32(sum);
                n_state = ST_M_P01;
            end
            ST_M_P01: begin
                mul_a = 34'(r_k0); mul_b = 34'(r_p01);
                n_state = ST_A_P01;
            end
            ST_A_P01: begin
                sum = 66'(r_p01) - 66'(r_prod >>> 30);
                n_ab = sat32(sum);
                n_state = ST_M_P10;
            end
            ST_M_P10: begin
                mul_a = 34'(r_k1); mul_b = 34'(r_p00);
                n_state = ST_A_P10;
            end
            ST_A_P10: begin
                sum = 66'(r_ba) - 66'(r_prod >>> 30);
                n_ba = sat32(sum);
                n_state = ST_M_P11;
            end
            ST_M_P11: begin
                mul_a = 34'(r_k1); mul_b = 34'(r_p01);
                n_state = ST_A_P11;
            end
            ST_A_P11: begin
                sum = 66'(r_bb) - 66'(r_prod >>> 30);
                n_bb = sat32(sum);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_odata = {r_rate, r_ang};
                n_ovalid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_q_angle <= QAngleRst;
            r_q_bias <= QBiasRst;
            r_r_measure <= RMeasureRst;
            r_ang <= '0; r_bias <= '0; r_rate <= '0;
            r_aa <= '0; r_ab <= '0; r_ba <= '0; r_bb <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_ang <= n_ang; r_bias <= n_bias; r_rate <= n_rate;
            r_aa <= n_aa; r_ab <= n_ab; r_ba <= n_ba; r_bb <= n_bb;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    RegQAngle:   r_q_angle <= i_cfg_wdata;
                    RegQBias:    r_q_bias <= i_cfg_wdata;
                    RegRMeasure: r_r_measure <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        r_p00 <= n_p00; r_p01 <= n_p01;
        r_meas <= n_meas; r_gyro <= n_gyro; r_dt <= n_dt;
        r_t <= n_t; r_k0 <= n_k0; r_k1 <= n_k1; r_y <= n_y; r_s <= n_s;
        r_dnum <= n_dnum;
        r_odata <= n_odata;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule
